[hdl/pta_pkg.sv]
// ----------------------------------------------------------------------------
// pta_pkg
// Shared types and constants for the partition table allocator: operation
// and status codes, beat payloads, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pta_pkg;

    // Default sizing
    localparam int DEF_MAX_ENTRIES = 32;
    localparam int DEF_ADDR_BITS   = 16;

    // Fixed field widths of the channel payloads
    localparam int OP_W     = 2;
    localparam int FIELD_W  = 16;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD      = 2'd0,
        OP_FIRST_FIT = 2'd1,
        OP_BEST_FIT  = 2'd2,
        OP_FREE      = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_NOFIT  = 2'd1,
        ST_FULL   = 2'd2,
        ST_NOADDR = 2'd3
    } t_status;

    typedef struct packed {
        t_op                op;
        logic [FIELD_W-1:0] addr;
        logic [FIELD_W-1:0] size;
    } t_in;

    typedef struct packed {
        t_status            status;
        logic [INDEX_W-1:0] entry_index;
        logic [FIELD_W-1:0] granted_start;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_DECIDE,
        S_WR_PICK,
        S_WR_REM,
        S_WR_FREE,
        S_RESULT
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic    start;     // request beat taken, latch it and clear the scan
        logic    scan;      // step the table scan
        logic    wr_load;   // append the loaded partition
        logic    wr_pick;   // cut the picked entry and mark it used
        logic    wr_rem;    // append the remainder as a free entry
        logic    wr_free;   // clear the used mark of the picked entry
        logic    res_set;   // record the outcome
        t_status res_status;
        logic    out_load;  // move the outcome into the output register
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        t_op  req_op;       // op of the beat on the input channel
        t_op  op;           // op of the request in progress
        logic full;
        logic scan_done;
        logic found;
        logic rem_nz;
        logic out_free;
    } t_sts;

endpackage

[hdl/pta_ctrl.sv]
// ----------------------------------------------------------------------------
// pta_ctrl
// Sequencer of the allocator: takes one request, runs the table scan,
// decides the outcome and issues the table writes and the result beat.
// ----------------------------------------------------------------------------
module pta_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pta_pkg::t_sts i_sts,
    output pta_pkg::t_cmd o_cmd
);
    import pta_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_start;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_start    = i_in_valid && o_in_ready;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_start) begin
                    n_state = (i_sts.req_op == OP_LOAD) ? S_LOAD : S_SCAN;
                end
            end
            S_LOAD: begin
                n_state = S_RESULT;
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!i_sts.found) begin
                    n_state = S_RESULT;
                end else if (i_sts.op == OP_FREE) begin
                    n_state = S_WR_FREE;
                end else if (i_sts.rem_nz && i_sts.full) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = S_WR_PICK;
                end
            end
            S_WR_PICK: begin
                n_state = i_sts.rem_nz ? S_WR_REM : S_RESULT;
            end
            S_WR_REM: begin
                n_state = S_RESULT;
            end
            S_WR_FREE: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd            = '0;
        o_cmd.res_status = ST_OK;
        o_cmd.start      = w_start;
        unique case (r_state)
            S_IDLE: begin
            end
            S_LOAD: begin
                o_cmd.res_set = 1'b1;
                if (i_sts.full) begin
                    o_cmd.res_status = ST_FULL;
                end else begin
                    o_cmd.wr_load = 1'b1;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_DECIDE: begin
                if (!i_sts.found) begin
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = (i_sts.op == OP_FREE) ? ST_NOADDR : ST_NOFIT;
                end else if (i_sts.op != OP_FREE && i_sts.rem_nz && i_sts.full) begin
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = ST_FULL;
                end
            end
            S_WR_PICK: begin
                o_cmd.wr_pick = 1'b1;
                o_cmd.res_set = !i_sts.rem_nz;
            end
            S_WR_REM: begin
                o_cmd.wr_rem  = 1'b1;
                o_cmd.res_set = 1'b1;
            end
            S_WR_FREE: begin
                o_cmd.wr_free = 1'b1;
                o_cmd.res_set = 1'b1;
            end
            S_RESULT: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

[hdl/pta_datapath.sv]
// ----------------------------------------------------------------------------
// pta_datapath
// Partition table memory, request registers, the one-entry-a-cycle scan
// with first-fit / best-fit / free matching, and the output register.
// ----------------------------------------------------------------------------
module pta_datapath #(
    parameter int MAX_ENTRIES = pta_pkg::DEF_MAX_ENTRIES,
    parameter int ADDR_BITS   = pta_pkg::DEF_ADDR_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pta_pkg::t_in  i_in,
    input  pta_pkg::t_cmd i_cmd,
    output pta_pkg::t_sts o_sts,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output pta_pkg::t_out o_out
);
    import pta_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    // Table storage, one write and one registered read per cycle
    logic [ADDR_BITS-1:0] mem_start [MAX_ENTRIES];
    logic [FIELD_W-1:0]   mem_size  [MAX_ENTRIES];
    logic                 mem_used  [MAX_ENTRIES];

    logic [ADDR_BITS-1:0] r_rd_start;
    logic [FIELD_W-1:0]   r_rd_size;
    logic                 r_rd_used;

    // Request
    t_op                  r_op;
    logic [ADDR_BITS-1:0] r_addr;
    logic [FIELD_W-1:0]   r_size;

    // Scan and pick
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_scan_idx;
    logic                 r_cmp_vld;
    logic [IDX_W-1:0]     r_cmp_idx;
    logic                 r_found;
    logic [IDX_W-1:0]     r_pick;
    logic [ADDR_BITS-1:0] r_pick_start;
    logic [FIELD_W-1:0]   r_pick_size;
    logic [FIELD_W-1:0]   r_best;

    t_status              r_res_status;
    logic                 r_out_valid;
    t_out                 r_out;

    logic                 w_full;
    logic                 w_issue;
    logic                 w_fits;
    logic                 w_match;
    logic [FIELD_W-1:0]   w_diff;
    logic                 w_take;
    logic                 w_stop;
    logic [FIELD_W-1:0]   w_rem;
    logic                 w_out_free;

    logic                 w_we;
    logic [IDX_W-1:0]     w_wa;
    logic [ADDR_BITS-1:0] w_wstart;
    logic [FIELD_W-1:0]   w_wsize;
    logic                 w_wused;

    assign w_full     = (r_count == CNT_W'(MAX_ENTRIES));
    assign w_issue    = i_cmd.scan && (r_scan_idx < r_count);
    assign w_rem      = r_pick_size - r_size;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Compare of the entry returned by the memory
    assign w_fits  = !r_rd_used && (r_rd_size >= r_size);
    assign w_match = r_rd_used && (r_rd_start == r_addr);
    assign w_diff  = r_rd_size - r_size;

    always_comb begin
        w_take = 1'b0;
        w_stop = 1'b0;
        case (r_op)
            OP_FIRST_FIT: begin
                w_take = w_fits;
                w_stop = w_fits;
            end
            OP_BEST_FIT: begin
                w_take = w_fits && (!r_found || (w_diff < r_best));
            end
            OP_FREE: begin
                w_take = w_match;
                w_stop = w_match;
            end
            default: begin
            end
        endcase
    end

    // Table write port
    always_comb begin
        w_we     = 1'b0;
        w_wa     = r_pick;
        w_wstart = r_pick_start;
        w_wsize  = r_pick_size;
        w_wused  = 1'b0;
        if (i_cmd.wr_load) begin
            w_we     = 1'b1;
            w_wa     = r_count[IDX_W-1:0];
            w_wstart = r_addr;
            w_wsize  = r_size;
        end else if (i_cmd.wr_pick) begin
            w_we    = 1'b1;
            w_wsize = r_size;
            w_wused = 1'b1;
        end else if (i_cmd.wr_rem) begin
            w_we     = 1'b1;
            w_wa     = r_count[IDX_W-1:0];
            w_wstart = r_pick_start + ADDR_BITS'(r_size);
            w_wsize  = w_rem;
        end else if (i_cmd.wr_free) begin
            w_we = 1'b1;
        end
    end

    // Table memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_start[w_wa] <= w_wstart;
            mem_size[w_wa]  <= w_wsize;
            mem_used[w_wa]  <= w_wused;
        end
        r_rd_start <= mem_start[r_scan_idx[IDX_W-1:0]];
        r_rd_size  <= mem_size[r_scan_idx[IDX_W-1:0]];
        r_rd_used  <= mem_used[r_scan_idx[IDX_W-1:0]];
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op   <= i_in.op;
            r_addr <= ADDR_BITS'(i_in.addr);
            r_size <= i_in.size;
        end
    end

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.wr_load || i_cmd.wr_rem) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // Scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
            r_cmp_vld  <= 1'b0;
            r_found    <= 1'b0;
        end else if (i_cmd.start) begin
            r_scan_idx <= '0;
            r_cmp_vld  <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            r_cmp_vld <= w_issue;
            if (w_issue) begin
                r_scan_idx <= r_scan_idx + CNT_W'(1);
            end
            if (i_cmd.scan && r_cmp_vld && w_take) begin
                r_found <= 1'b1;
            end
        end
    end

    // Pick registers; a load reuses them to report its slot
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_cmp_idx <= r_scan_idx[IDX_W-1:0];
        end
        if (i_cmd.wr_load) begin
            r_pick       <= r_count[IDX_W-1:0];
            r_pick_start <= r_addr;
        end else if (i_cmd.scan && r_cmp_vld && w_take) begin
            r_pick       <= r_cmp_idx;
            r_pick_start <= r_rd_start;
            r_pick_size  <= r_rd_size;
            r_best       <= w_diff;
        end
    end

    // Outcome and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_status;
        end
        if (i_cmd.out_load) begin
            r_out.status <= r_res_status;
            if (r_res_status == ST_OK) begin
                r_out.entry_index   <= INDEX_W'(r_pick);
                r_out.granted_start <= FIELD_W'(r_pick_start);
            end else begin
                r_out.entry_index   <= '0;
                r_out.granted_start <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Status to the controller
    always_comb begin
        o_sts.req_op    = i_in.op;
        o_sts.op        = r_op;
        o_sts.full      = w_full;
        o_sts.scan_done = (r_cmp_vld && w_stop) || (!r_cmp_vld && r_scan_idx == r_count);
        o_sts.found     = r_found;
        o_sts.rem_nz    = (w_rem != '0);
        o_sts.out_free  = w_out_free;
    end

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond table depth");

    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_load || i_cmd.wr_rem) |-> !w_full)
        else $error("append into a full table");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.wr_load, i_cmd.wr_pick, i_cmd.wr_rem, i_cmd.wr_free}))
        else $error("more than one table write in a cycle");

    a_out_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> w_out_free)
        else $error("result beat overwritten before it was taken");

    a_pick_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_pick || i_cmd.wr_free) |-> (r_found && (CNT_W'(r_pick) < r_count)))
        else $error("write to an entry outside the table");

endmodule

[hdl/partition_table_allocator_core.sv]
// ----------------------------------------------------------------------------
// partition_table_allocator_core
// Table of variable partitions with load, first-fit, best-fit and free.
//
// Input channel (i_in_valid / o_in_ready, payload i_in): one request beat of
// op, addr and size. Output channel (o_out_valid / i_out_ready, payload
// o_out): exactly one result beat per request with status, entry index and
// granted start address.
// One request is handled at a time. A load passes the load state and then
// the result state, which fills the output register. An allocation or free
// walks the table one entry a cycle through the single read port of the
// table memory, then the decide state; on success it writes the picked
// entry and, for a split, the remainder, or clears the used mark for a
// free, and the result state fills the output register. First-fit and free
// stop at the first matching entry. Once the result is registered the block
// returns to idle and takes the next request, even while that result waits.
// A stalled receiver holds the block once a further result is ready to go out.
// Reset empties the table (entry count to zero) and drops any pending
// result; the table memory itself needs no clearing.
// ----------------------------------------------------------------------------
module partition_table_allocator_core #(
    parameter int MAX_ENTRIES = pta_pkg::DEF_MAX_ENTRIES,
    parameter int ADDR_BITS   = pta_pkg::DEF_ADDR_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pta_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output pta_pkg::t_out o_out
);
    import pta_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer
    pta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Table, scan and output register
    pta_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ADDR_BITS   (ADDR_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for partition_table_allocator_core. A behavioural copy
// of the partition table predicts the result of every request beat as it is
// accepted, and a monitor compares each result beat against the oldest
// prediction. Directed requests cover the corner cases. Random traffic, shaped
// around the live table contents, then runs under three idling mixes. A long
// receiver hold-off and a full drain pause stress the handshakes.
// ----------------------------------------------------------------------------
module tb_top;
    import pta_pkg::*;

    localparam int TBL_DEPTH    = DEF_MAX_ENTRIES;
    localparam int RUN_LIMIT_NS = 5_000_000;
    localparam int TAIL_CYCLES  = DEF_MAX_ENTRIES + 30;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in        = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out;

    // Predicted table contents
    logic [FIELD_W-1:0] tbl_start [TBL_DEPTH];
    logic [FIELD_W-1:0] tbl_size  [TBL_DEPTH];
    logic               tbl_used  [TBL_DEPTH];
    int                 tbl_count = 0;

    t_out expected_results [$];
    int   fail_count      = 0;
    int   snd_idle_pct    = 0;
    int   rcv_idle_pct    = 0;
    int   hold_off_cycles = 0;

    partition_table_allocator_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Partition table predictor
    // ------------------------------------------------------------------------
    function automatic void append_free(input logic [FIELD_W-1:0] start,
                                        input logic [FIELD_W-1:0] size);
        tbl_start[tbl_count] = start;
        tbl_size[tbl_count]  = size;
        tbl_used[tbl_count]  = 1'b0;
        tbl_count++;
    endfunction

    function automatic t_out partition_predict(input t_in req);
        t_out               res;
        int                 idx;
        int                 pick;
        logic [FIELD_W-1:0] diff;
        logic [FIELD_W-1:0] best_diff;
        res       = '0;
        pick      = -1;
        best_diff = '0;
        case (req.op)
            OP_LOAD: begin
                if (tbl_count >= TBL_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    res.entry_index   = INDEX_W'(tbl_count);
                    res.granted_start = req.addr;
                    append_free(req.addr, req.size);
                end
            end
            OP_FREE: begin
                // lowest-index used entry at that address wins
                res.status = ST_NOADDR;
                for (idx = 0; idx < tbl_count; idx++) begin
                    if (tbl_used[idx] && tbl_start[idx] == req.addr) begin
                        tbl_used[idx]     = 1'b0;
                        res.status        = ST_OK;
                        res.entry_index   = INDEX_W'(idx);
                        res.granted_start = req.addr;
                        break;
                    end
                end
            end
            default: begin
                // first-fit stops at the first candidate, best-fit keeps the
                // strictly smallest leftover so ties stay on the lower index
                for (idx = 0; idx < tbl_count; idx++) begin
                    if (!tbl_used[idx] && tbl_size[idx] >= req.size) begin
                        diff = tbl_size[idx] - req.size;
                        if (pick < 0 || (req.op == OP_BEST_FIT && diff < best_diff)) begin
                            pick      = idx;
                            best_diff = diff;
                        end
                        if (req.op == OP_FIRST_FIT) break;
                    end
                end
                if (pick < 0) begin
                    res.status = ST_NOFIT;
                end else if (best_diff != '0 && tbl_count >= TBL_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    res.entry_index   = INDEX_W'(pick);
                    res.granted_start = tbl_start[pick];
                    tbl_used[pick]    = 1'b1;
                    tbl_size[pick]    = req.size;
                    // remainder start wraps with the address width
                    if (best_diff != '0) append_free(tbl_start[pick] + req.size, best_diff);
                end
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Request generation, mostly aimed at what the table holds right now
    // ------------------------------------------------------------------------
    function automatic t_in random_req();
        t_in req;
        int  free_ids [$];
        int  used_ids [$];
        int  roll;
        int  j;
        for (j = 0; j < tbl_count; j++) begin
            if (tbl_used[j]) used_ids.push_back(j);
            else free_ids.push_back(j);
        end
        req.op   = t_op'(OP_W'($urandom_range(3)));
        req.addr = FIELD_W'($urandom);
        req.size = FIELD_W'($urandom);
        roll     = $urandom_range(99);
        if (roll < 15) begin
            req.op = OP_LOAD;
            if ($urandom_range(1)) req.size = FIELD_W'($urandom_range(255));
        end else if (roll < 55) begin
            req.op = $urandom_range(1) ? OP_FIRST_FIT : OP_BEST_FIT;
            if (free_ids.size() != 0 && $urandom_range(9) < 8) begin
                j = free_ids[$urandom_range(free_ids.size() - 1)];
                case ($urandom_range(3))
                    0, 1:    req.size = tbl_size[j];
                    2:       req.size = tbl_size[j] - FIELD_W'($urandom_range(
                                 tbl_size[j] < 16 ? tbl_size[j] : 16));
                    default: req.size = FIELD_W'($urandom_range(3));
                endcase
            end
        end else if (roll < 85) begin
            req.op = OP_FREE;
            if (used_ids.size() != 0 && $urandom_range(9) < 8)
                req.addr = tbl_start[used_ids[$urandom_range(used_ids.size() - 1)]];
            else if (free_ids.size() != 0 && $urandom_range(1))
                req.addr = tbl_start[free_ids[$urandom_range(free_ids.size() - 1)]];
        end
        return req;
    endfunction

    // ------------------------------------------------------------------------
    // Request channel: one beat, prediction taken at the accepting edge.
    // Valid is left high on return; a drain, or an idle gap before the next send, takes it down.
    // ------------------------------------------------------------------------
    task automatic send_req(input t_in req);
        int gap;
        gap = 0;
        while ($urandom_range(99) < snd_idle_pct) gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in       <= req;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_results.push_back(partition_predict(req));
    endtask

    task automatic send_op(input t_op op, input logic [FIELD_W-1:0] addr,
                           input logic [FIELD_W-1:0] size);
        t_in req;
        req.op   = op;
        req.addr = addr;
        req.size = size;
        send_req(req);
    endtask

    // Stop offering and wait until every predicted result has been seen
    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Result channel: random ready, with an optional long hold-off
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_off_cycles != 0) begin
            i_out_ready     <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Result monitor
    always @(posedge i_clk) begin : result_check
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result beat with no request outstanding: %p", o_out);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_out.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out.status);
                    fail_count++;
                end
                if (o_out.entry_index !== want.entry_index) begin
                    $error("entry_index: expected %0d, got %0d",
                           want.entry_index, o_out.entry_index);
                    fail_count++;
                end
                if (o_out.granted_start !== want.granted_start) begin
                    $error("granted_start: expected 0x%04h, got 0x%04h",
                           want.granted_start, o_out.granted_start);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_ops();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        // empty table: nothing to free, nothing fits
        send_op(OP_FREE,      16'h1234, 16'h0000);
        send_op(OP_FIRST_FIT, 16'h0000, 16'h0001);
        send_op(OP_BEST_FIT,  16'h0000, 16'h0000);
        // loads, including a zero-size partition and the largest size
        send_op(OP_LOAD,      16'hFFF0, 16'h0030);
        send_op(OP_LOAD,      16'h0000, 16'h0000);
        send_op(OP_LOAD,      16'h1000, 16'd100);
        send_op(OP_LOAD,      16'h2000, 16'd60);
        send_op(OP_LOAD,      16'h3000, 16'd60);
        send_op(OP_LOAD,      16'h4000, 16'hFFFF);
        // first-fit split, best-fit tie on an exact fit
        send_op(OP_FIRST_FIT, 16'h0000, 16'd50);
        send_op(OP_BEST_FIT,  16'h0000, 16'd60);
        // best-fit split whose remainder start wraps past the top address
        send_op(OP_BEST_FIT,  16'h0000, 16'd40);
        // zero-size requests: onto a zero-size entry, then onto a sized one
        send_op(OP_FIRST_FIT, 16'h0000, 16'h0000);
        send_op(OP_BEST_FIT,  16'h0000, 16'h0000);
        send_op(OP_FIRST_FIT, 16'h0000, 16'hFFFF);
        send_op(OP_BEST_FIT,  16'h0000, 16'hFFFF);
        // shared start address: free hits the used one only, once
        send_op(OP_FREE,      16'h0018, 16'h0000);
        send_op(OP_FREE,      16'h0018, 16'h0000);
        send_op(OP_FREE,      16'h1000, 16'h0000);
        send_op(OP_FREE,      16'h4000, 16'h0000);
        send_op(OP_LOAD,      16'hFFFF, 16'hFFFF);
        send_op(OP_LOAD,      16'hAAAA, 16'h5555);
        send_op(OP_LOAD,      16'h5555, 16'hAAAA);
        send_op(OP_FIRST_FIT, 16'h0000, 16'h8000);
        send_op(OP_FREE,      16'hFFF0, 16'h0000);
        wait_all_results();
    endtask

    task automatic test_random_traffic(input int n_items, input int snd_pct,
                                       input int rcv_pct);
        int n;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        for (n = 0; n < n_items; n++) send_req(random_req());
        wait_all_results();
    endtask

    task automatic test_table_full();
        int j;
        int tried;
        snd_idle_pct = 5;
        rcv_idle_pct = 20;
        while (tbl_count < TBL_DEPTH)
            send_op(OP_LOAD, FIELD_W'($urandom), FIELD_W'($urandom_range(1, 4095)));
        send_op(OP_LOAD, 16'h7000, 16'h0100);
        // splits cannot append any more; exact fits still go through
        tried = 0;
        for (j = 0; j < TBL_DEPTH && tried < 4; j++) begin
            if (!tbl_used[j] && tbl_size[j] > 1) begin
                send_op(OP_BEST_FIT,  16'h0000, tbl_size[j] - 16'd1);
                send_op(OP_FIRST_FIT, 16'h0000, tbl_size[j]);
                send_op(OP_FREE,      tbl_start[j], 16'h0000);
                tried++;
            end
        end
        wait_all_results();
    endtask

    task automatic test_output_backpressure();
        int n;
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        // receiver goes quiet while requests keep coming, so the block fills
        hold_off_cycles <= 600;
        for (n = 0; n < 12; n++) send_req(random_req());
        // sender pauses until everything is back
        wait_all_results();
        for (n = 0; n < 12; n++) send_req(random_req());
        wait_all_results();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_ops();
        test_random_traffic(530, 13, 62);
        test_table_full();
        test_output_backpressure();
        test_random_traffic(530, 62, 13);
        test_random_traffic(480, 0, 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("partition_table_allocator_core test passed");
        end else begin
            $display("partition_table_allocator_core test failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(RUN_LIMIT_NS);
        $display("partition_table_allocator_core test failed");
        $finish;
    end

endmodule
